// ----- rtl/kmer_pkg.sv -----
// shared types and constants for the k-mer extraction and dedup block
package kmer_pkg;

    localparam int MAX_KMER    = 32;
    localparam int TABLE_DEPTH = 4096;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int ID_W        = 12;
    localparam int CNT_W       = 13;
    localparam int KMER_W      = 64;
    localparam int SEQ_W       = 16;
    localparam int LEN_W       = 6;
    localparam int FILL_W      = 6;
    localparam int ENTRY_W     = 1 + ID_W + KMER_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0]  ID_LIMIT = CNT_W'(4096);
    localparam logic [63:0]       HASH_MUL = 64'h9E3779B97F4A7C15;
    localparam logic [31:0]       OCC_MAX  = 32'hFFFFFFFF;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic REG_KMER_LEN = 1'b0;
    localparam logic REG_UNIQUE   = 1'b1;

    typedef struct packed {
        logic               clear;
        logic [KMER_W-1:0]  kmer;
        logic [SEQ_W-1:0]   seq;
    } t_job;

    typedef struct packed {
        logic busy_clear;
    } t_back_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_HASH,
        ST_READ,
        ST_CMP,
        ST_OUT
    } t_state;

endpackage

// ----- rtl/kmer_ram.sv -----
// generic single write port ram with registered read
module kmer_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/kmer_front.sv -----
// front end: nucleotide window, k-mer extraction and job issue
module kmer_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_command,
    input  logic [1:0]                   i_nucleotide,
    input  logic                         i_seq_start,
    input  logic [kmer_pkg::SEQ_W-1:0]   i_seq_index,
    input  logic [kmer_pkg::LEN_W-1:0]   i_klen,
    input  kmer_pkg::t_back_status       i_status,
    input  logic                         i_q_full,
    output logic                         o_push,
    output kmer_pkg::t_job               o_job
);

    logic [kmer_pkg::KMER_W-1:0] r_window, n_window;
    logic [kmer_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [kmer_pkg::FILL_W-1:0] fill_base;
    logic [kmer_pkg::LEN_W-1:0]  len;
    logic [6:0]                  shamt;
    logic                        accept;

    assign o_ready = !i_q_full && !i_status.busy_clear;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (i_klen == '0) begin
            len = kmer_pkg::LEN_W'(1);
        end else if (i_klen > kmer_pkg::LEN_W'(kmer_pkg::MAX_KMER)) begin
            len = kmer_pkg::LEN_W'(kmer_pkg::MAX_KMER);
        end else begin
            len = i_klen;
        end
        fill_base = i_seq_start ? '0 : r_fill;
        n_window  = {i_nucleotide, (i_seq_start ? 62'd0 : r_window[63:2])};
        n_fill    = (fill_base < kmer_pkg::FILL_W'(kmer_pkg::MAX_KMER))
                  ? fill_base + 1'b1 : fill_base;
        shamt     = 7'd64 - {len, 1'b0};
        o_job.clear = (i_command == kmer_pkg::CMD_CLEAR);
        o_job.kmer  = n_window >> shamt;
        o_job.seq   = i_seq_index;
        o_push      = accept && ((i_command == kmer_pkg::CMD_CLEAR) || (n_fill >= len));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_fill   <= '0;
        end else if (accept && i_command == kmer_pkg::CMD_PUSH) begin
            r_window <= n_window;
            r_fill   <= n_fill;
        end
    end

endmodule

// ----- rtl/kmer_queue.sv -----
// short job queue between front and back
module kmer_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kmer_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output kmer_pkg::t_job o_job
);

    kmer_pkg::t_job                r_slots [kmer_pkg::QUEUE_DEPTH];
    logic [kmer_pkg::QUEUE_AW-1:0] r_wptr, r_rptr;
    logic [kmer_pkg::QUEUE_AW:0]   r_count;
    logic                          do_push, do_pop;

    assign o_full  = (r_count == (kmer_pkg::QUEUE_AW+1)'(kmer_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_slots[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            r_count <= r_count + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
        end
    end

endmodule

// ----- rtl/kmer_back.sv -----
// back end: table clear, hash, probe, insert and result register
module kmer_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_unique,
    input  logic                          i_q_empty,
    input  kmer_pkg::t_job                i_job,
    output logic                          o_pop,
    output kmer_pkg::t_back_status        o_status,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [kmer_pkg::KMER_W-1:0]   o_kmer_value,
    output logic [kmer_pkg::ID_W-1:0]     o_kmer_id,
    output logic [kmer_pkg::SEQ_W-1:0]    o_seq_number,
    output logic                          o_is_new,
    output logic                          o_table_full,
    output logic [kmer_pkg::CNT_W-1:0]    o_unique_count,
    output logic [31:0]                   o_entry_number
);

    localparam int AW = kmer_pkg::TABLE_AW;

    kmer_pkg::t_state r_state, n_state;

    logic [AW-1:0]                 r_caddr, n_caddr;
    logic [AW-1:0]                 r_slot, n_slot;
    logic [AW-1:0]                 r_probes, n_probes;
    logic [1:0]                    r_step, n_step;
    logic [63:0]                   r_prod, r_acc, n_acc, hash;
    logic [31:0]                   mul_a, mul_b;
    logic [kmer_pkg::CNT_W-1:0]    r_next_id, n_next_id;
    logic [31:0]                   r_occ, n_occ;
    logic [kmer_pkg::KMER_W-1:0]   r_kmer, n_kmer;
    logic [kmer_pkg::SEQ_W-1:0]    r_seq, n_seq;
    logic [kmer_pkg::ID_W-1:0]     r_id, n_id;
    logic                          r_new, n_new, r_full, n_full;
    logic [kmer_pkg::CNT_W-1:0]    r_ucnt, n_ucnt;
    logic [31:0]                   r_entry, n_entry;

    logic                          we;
    logic [AW-1:0]                 waddr;
    logic [kmer_pkg::ENTRY_W-1:0]  wdata, rdata;
    logic                          rd_valid;
    logic [kmer_pkg::ID_W-1:0]     rd_id;
    logic [kmer_pkg::KMER_W-1:0]   rd_key;

    kmer_ram #(
        .WIDTH (kmer_pkg::ENTRY_W),
        .DEPTH (kmer_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_slot),
        .o_rdata (rdata)
    );

    assign rd_valid = rdata[kmer_pkg::ENTRY_W-1];
    assign rd_id    = rdata[kmer_pkg::KMER_W +: kmer_pkg::ID_W];
    assign rd_key   = rdata[kmer_pkg::KMER_W-1:0];

    assign mul_a = (r_step == 2'd1) ? r_kmer[63:32] : r_kmer[31:0];
    assign mul_b = (r_step == 2'd2) ? kmer_pkg::HASH_MUL[63:32] : kmer_pkg::HASH_MUL[31:0];
    assign hash  = r_acc ^ (r_acc >> 29);

    assign o_status.busy_clear = (r_state == kmer_pkg::ST_CLEAR);

    always_comb begin
        n_state   = r_state;
        n_caddr   = r_caddr;
        n_slot    = r_slot;
        n_probes  = r_probes;
        n_step    = r_step;
        n_acc     = r_acc;
        n_next_id = r_next_id;
        n_occ     = r_occ;
        n_kmer    = r_kmer;
        n_seq     = r_seq;
        n_id      = r_id;
        n_new     = r_new;
        n_full    = r_full;
        n_ucnt    = r_ucnt;
        n_entry   = r_entry;
        o_pop     = 1'b0;
        we        = 1'b0;
        waddr     = r_slot;
        wdata     = {1'b1, r_next_id[kmer_pkg::ID_W-1:0], r_kmer};
        case (r_state)
            kmer_pkg::ST_CLEAR: begin
                we      = 1'b1;
                waddr   = r_caddr;
                wdata   = '0;
                n_caddr = r_caddr + 1'b1;
                if (r_caddr == {AW{1'b1}}) n_state = kmer_pkg::ST_IDLE;
            end
            kmer_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop  = 1'b1;
                    n_kmer = i_job.kmer;
                    n_seq  = i_job.seq;
                    n_step = '0;
                    n_acc  = '0;
                    if (i_job.clear) begin
                        n_next_id = '0;
                        n_occ     = '0;
                        n_caddr   = '0;
                        n_state   = kmer_pkg::ST_CLEAR;
                    end else if (i_unique) begin
                        n_state = kmer_pkg::ST_MUL;
                    end else begin
                        n_entry = r_occ;
                        if (r_occ != kmer_pkg::OCC_MAX) n_occ = r_occ + 1'b1;
                        if (r_next_id < kmer_pkg::ID_LIMIT) begin
                            n_id      = r_next_id[kmer_pkg::ID_W-1:0];
                            n_new     = 1'b1;
                            n_full    = 1'b0;
                            n_next_id = r_next_id + 1'b1;
                        end else begin
                            n_id   = '0;
                            n_new  = 1'b0;
                            n_full = 1'b1;
                        end
                        n_ucnt  = n_next_id;
                        n_state = kmer_pkg::ST_OUT;
                    end
                end
            end
            kmer_pkg::ST_MUL: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    2'd0:    n_acc = r_acc;
                    2'd1:    n_acc = r_prod;
                    default: n_acc = r_acc + {r_prod[31:0], 32'd0};
                endcase
                if (r_step == 2'd3) n_state = kmer_pkg::ST_HASH;
            end
            kmer_pkg::ST_HASH: begin
                n_slot   = hash[16 +: AW];
                n_probes = '0;
                n_state  = kmer_pkg::ST_READ;
            end
            kmer_pkg::ST_READ: begin
                n_state = kmer_pkg::ST_CMP;
            end
            kmer_pkg::ST_CMP: begin
                if (!rd_valid || rd_key == r_kmer || r_probes == {AW{1'b1}}) begin
                    n_entry = r_occ;
                    if (r_occ != kmer_pkg::OCC_MAX) n_occ = r_occ + 1'b1;
                    n_state = kmer_pkg::ST_OUT;
                    n_id    = '0;
                    n_new   = 1'b0;
                    n_full  = 1'b1;
                    if (!rd_valid) begin
                        if (r_next_id < kmer_pkg::ID_LIMIT) begin
                            we        = 1'b1;
                            n_id      = r_next_id[kmer_pkg::ID_W-1:0];
                            n_new     = 1'b1;
                            n_full    = 1'b0;
                            n_next_id = r_next_id + 1'b1;
                        end
                    end else if (rd_key == r_kmer) begin
                        n_id   = rd_id;
                        n_full = 1'b0;
                    end
                    n_ucnt = n_next_id;
                end else begin
                    n_slot   = r_slot + 1'b1;
                    n_probes = r_probes + 1'b1;
                    n_state  = kmer_pkg::ST_READ;
                end
            end
            kmer_pkg::ST_OUT: begin
                if (i_ready) n_state = kmer_pkg::ST_IDLE;
            end
            default: n_state = kmer_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kmer_pkg::ST_CLEAR;
            r_caddr   <= '0;
            r_next_id <= '0;
            r_occ     <= '0;
        end else begin
            r_state   <= n_state;
            r_caddr   <= n_caddr;
            r_next_id <= n_next_id;
            r_occ     <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= mul_a * mul_b;
        r_slot   <= n_slot;
        r_probes <= n_probes;
        r_step   <= n_step;
        r_acc    <= n_acc;
        r_kmer   <= n_kmer;
        r_seq    <= n_seq;
        r_id     <= n_id;
        r_new    <= n_new;
        r_full   <= n_full;
        r_ucnt   <= n_ucnt;
        r_entry  <= n_entry;
    end

    assign o_valid        = (r_state == kmer_pkg::ST_OUT);
    assign o_kmer_value   = r_kmer;
    assign o_kmer_id      = r_id;
    assign o_seq_number   = r_seq;
    assign o_is_new       = r_new;
    assign o_table_full   = r_full;
    assign o_unique_count = r_ucnt;
    assign o_entry_number = r_entry;

    a_id_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id <= kmer_pkg::ID_LIMIT)
        else $error("id counter beyond limit");

    a_full_not_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_new && o_table_full))
        else $error("result both new and full");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == kmer_pkg::ST_IDLE))
        else $error("job taken while busy");

    a_new_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != kmer_pkg::ST_OUT && o_valid == 1'b0 && n_state == kmer_pkg::ST_OUT
         && n_new) |=> (r_next_id == $past(r_next_id) + 1'b1))
        else $error("new id without counter step");

endmodule

// ----- rtl/kmer_extract_and_dedup.sv -----
// top level: k-mer extraction with hash table dedup
// the back end finishes one k-mer before it takes the next from the job queue;
// with dedup its pace is set by the shared 32x32 hash multiplier and the table
// read on each probe
// reset, and each clear command, sweep the 4096-entry table
// with input held off; configuration resets to length 16, unique mode on
module kmer_extract_and_dedup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [kmer_pkg::LEN_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_command,
    input  logic [1:0]                    i_nucleotide,
    input  logic                          i_seq_start,
    input  logic [kmer_pkg::SEQ_W-1:0]    i_seq_index,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [kmer_pkg::KMER_W-1:0]   o_kmer_value,
    output logic [kmer_pkg::ID_W-1:0]     o_kmer_id,
    output logic [kmer_pkg::SEQ_W-1:0]    o_seq_number,
    output logic                          o_is_new,
    output logic                          o_table_full,
    output logic [kmer_pkg::CNT_W-1:0]    o_unique_count,
    output logic [31:0]                   o_entry_number
);

    logic [kmer_pkg::LEN_W-1:0] r_klen;
    logic                       r_unique;
    kmer_pkg::t_back_status     status;
    kmer_pkg::t_job             push_job, pop_job;
    logic                       push, pop, q_full, q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen   <= kmer_pkg::LEN_W'(16);
            r_unique <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kmer_pkg::REG_KMER_LEN: r_klen   <= i_cfg_data;
                kmer_pkg::REG_UNIQUE:   r_unique <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    kmer_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_nucleotide (i_nucleotide),
        .i_seq_start  (i_seq_start),
        .i_seq_index  (i_seq_index),
        .i_klen       (r_klen),
        .i_status     (status),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    kmer_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (pop_job)
    );

    kmer_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_unique       (r_unique),
        .i_q_empty      (q_empty),
        .i_job          (pop_job),
        .o_pop          (pop),
        .o_status       (status),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kmer_value   (o_kmer_value),
        .o_kmer_id      (o_kmer_id),
        .o_seq_number   (o_seq_number),
        .o_is_new       (o_is_new),
        .o_table_full   (o_table_full),
        .o_unique_count (o_unique_count),
        .o_entry_number (o_entry_number)
    );

endmodule
